>>> rtl/zbdt_pkg.sv
`default_nettype none

package zbdt_pkg;

  // depth store size, a power of two
  localparam int unsigned BUFFER_WORDS = 65536;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_WORDS);

  localparam int unsigned INDEX_W = 16;
  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned CFG_W   = 2;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // compare functions
  typedef enum logic [1:0] {
    FUNC_NEVER   = 2'd0,
    FUNC_LESS    = 2'd1,
    FUNC_GREATER = 2'd2,
    FUNC_ALWAYS  = 2'd3
  } depth_func_t;

  // configuration register indexes
  localparam logic CFG_DEPTH_FUNC  = 1'b0;
  localparam logic CFG_DEPTH_WRITE = 1'b1;

  // input item kinds
  localparam logic MODE_TEST = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

endpackage

`default_nettype wire

>>> rtl/zbuffer_depth_test_unit.sv
`default_nettype none

// Z-buffer depth test. Each input transaction carries a pixel index and a
// signed fragment depth (test mode) or a value to load (load mode). The stored
// depth at that index is compared with the fragment under the compare function
// in depth_func; the result transaction gives the wrapped 32-bit difference
// (all ones under the always function, zero under never) and the pass flag from
// the true signed comparison. A passing fragment replaces the stored depth when
// depth_write is set; load mode always writes and returns zeros. The block
// accepts one transaction per clock unless the result stream stalls; the
// synchronous read of the depth memory happens on the accepting edge, and
// compare and write-back load the output register when the compare stage
// advances. A write and a read of the same entry on the same edge are resolved
// by forwarding the written value. The pixel index wraps modulo the store size
// (low address bits). The store has no reset: entries read before being written
// are unspecified, and there is no clearing pass. Configuration is written
// through cfg_we/cfg_index/cfg_wdata and must only change while the block is idle.

module zbuffer_depth_test_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [zbdt_pkg::CFG_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic                        in_tvalid,
  output      logic                        in_tready,
  input  wire logic [47:0]                 in_tdata,   // pixel_index[15:0], frag_depth[47:16]
  input  wire logic [0:0]                  in_tuser,   // mode[0]
  // result stream
  output      logic                        out_tvalid,
  input  wire logic                        out_tready,
  output      logic [39:0]                 out_tdata   // difference[31:0], pass[32], zero pad
);

  // configuration registers
  zbdt_pkg::depth_func_t depth_func_r;
  logic                  depth_write_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_func_r  <= zbdt_pkg::FUNC_LESS;
      depth_write_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        zbdt_pkg::CFG_DEPTH_FUNC:  depth_func_r  <= zbdt_pkg::depth_func_t'(cfg_wdata);
        zbdt_pkg::CFG_DEPTH_WRITE: depth_write_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input field unpacking
  logic                       in_mode;
  logic [zbdt_pkg::INDEX_W-1:0] in_pixel_index;
  zbdt_pkg::depth_t           in_frag_depth;
  zbdt_pkg::addr_t            in_addr;

  assign in_mode        = in_tuser[0];
  assign in_pixel_index = in_tdata[15:0];
  assign in_frag_depth  = in_tdata[47:16];
  // wrap modulo the store size
  assign in_addr        = zbdt_pkg::ADDR_W'(in_pixel_index);

  // compare stage registers
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_mode_r;
  zbdt_pkg::addr_t  s1_addr_r;
  zbdt_pkg::depth_t s1_frag_r;

  // forwarding of a write that lands on the edge of our read
  logic             fwd_hit_r;
  zbdt_pkg::depth_t fwd_data_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  zbdt_pkg::depth_t out_diff_r;
  logic             out_pass_r;

  logic in_acc;
  logic s1_adv;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // depth memory, synchronous read into rd_data_r
  zbdt_pkg::depth_t depth_mem [zbdt_pkg::BUFFER_WORDS];
  zbdt_pkg::depth_t rd_data_r;

  logic             mem_we;
  zbdt_pkg::depth_t stored;
  zbdt_pkg::depth_t diff;
  logic             pass;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[s1_addr_r] <= s1_frag_r;
    end
    if (in_acc) begin
      rd_data_r <= depth_mem[in_addr];
    end
  end

  // stored value seen by the compare stage
  assign stored = fwd_hit_r ? fwd_data_r : rd_data_r;

  always_comb begin
    diff = '0;
    pass = 1'b0;
    if (s1_mode_r == zbdt_pkg::MODE_TEST) begin
      case (depth_func_r)
        zbdt_pkg::FUNC_LESS: begin
          diff = s1_frag_r - stored;
          pass = $signed(s1_frag_r) < $signed(stored);
        end
        zbdt_pkg::FUNC_GREATER: begin
          diff = stored - s1_frag_r;
          pass = $signed(s1_frag_r) > $signed(stored);
        end
        zbdt_pkg::FUNC_ALWAYS: begin
          diff = '1;
          pass = 1'b1;
        end
        default: begin
          diff = '0;
          pass = 1'b0;
        end
      endcase
    end
  end

  // load mode always writes, test mode on a pass with writes enabled
  assign mem_we = s1_adv && ((s1_mode_r == zbdt_pkg::MODE_LOAD) || (pass && depth_write_r));

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        // a write on this edge to the same entry is missed by the read
        fwd_hit_r <= mem_we && (s1_addr_r == in_addr);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_mode;
      s1_addr_r  <= in_addr;
      s1_frag_r  <= in_frag_depth;
      fwd_data_r <= s1_frag_r;
    end
    if (s1_adv) begin
      out_diff_r <= diff;
      out_pass_r <= pass;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pass_r, out_diff_r};

  // a write colliding with the read of the same entry is forwarded
  a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mem_we && (s1_addr_r == in_addr)) |=> fwd_hit_r)
    else $error("colliding write not forwarded");

  // an accepted transaction sits in the compare stage next cycle
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction lost before compare");

  // a load returns zeros
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_mode_r == zbdt_pkg::MODE_LOAD)) |=> (out_tdata == '0))
    else $error("load mode result not zero");

  // never-function fragments never pass nor write
  a_never_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_mode_r == zbdt_pkg::MODE_TEST) && (depth_func_r == zbdt_pkg::FUNC_NEVER))
      |-> !mem_we)
    else $error("store written under never function");

  // a result is produced in the cycle after the compare stage advances
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("compare result not presented");

endmodule

`default_nettype wire
